[hdl/metr_pkg.sv]
// ----------------------------------------------------------------------------
// metr_pkg
// Shared types and codes for the Manchester edge-timing receiver.
// ----------------------------------------------------------------------------
package metr_pkg;

	// receiver states, one-hot
	typedef enum logic [6:0] {
		ST_WAITING   = 7'b0000001,
		ST_SYNC_HIGH = 7'b0000010,
		ST_SYNC_LOW  = 7'b0000100,
		ST_INIT      = 7'b0001000,
		ST_MID       = 7'b0010000,
		ST_START     = 7'b0100000,
		ST_ERROR     = 7'b1000000
	} metr_state_t;

	// event codes on the result word
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_SYNC = 2'd1;
	localparam logic [1:0] EV_BIT  = 2'd2;

	// tolerance is 1/64 of the measured time
	localparam int unsigned TOL_SHIFT = 6;

	// event and decoded bit for one edge
	typedef struct packed {
		logic [1:0] event_res;
		logic       bit_value;
	} metr_res_t;

endpackage

[hdl/manchester_edge_timing_receiver.sv]
// ----------------------------------------------------------------------------
// manchester_edge_timing_receiver
// Manchester receiver working on edge timestamps: locks on a high/low sync
// pair, learns the bit period and decodes data bits from edge intervals.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | input     | in_valid / in_stall    | level, edge_time
//   out     | output    | out_valid / out_stall  | event_res, bit_value,
//           |           |                        | learned_half_period
//
// One word per cycle sustained while out_stall is low; an edge passes
// through the input register, then through the edge logic into the
// result register. The receiver state updates as the word enters the result
// register. Reset clears the state to waiting with all times at zero.
// A stalled result holds; one further word may wait in the input register.
// ----------------------------------------------------------------------------
module manchester_edge_timing_receiver #(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        level,
	input  logic [31:0] edge_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_res,
	output logic        bit_value,
	output logic [31:0] learned_half_period
);
	import metr_pkg::*;

	logic                 valid_s1;
	logic                 level_s1;
	logic [31:0]          time_s1;
	logic                 out_ready;
	logic                 adv;

	metr_state_t          state_q;
	metr_state_t          state_n;
	logic [TIME_BITS-1:0] mark_q;
	logic [TIME_BITS-1:0] high_q;
	logic [TIME_BITS-1:0] full_q;
	logic [TIME_BITS-1:0] half_q;
	logic [TIME_BITS-1:0] mark_n;
	logic [TIME_BITS-1:0] high_n;
	logic [TIME_BITS-1:0] full_n;
	logic [TIME_BITS-1:0] half_n;
	metr_res_t            res;

	logic                 out_valid_q;
	metr_res_t            res_q;
	logic [31:0]          half_out_q;

	// handshake
	assign out_ready = !out_valid_q || !out_stall;
	assign adv       = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= level;
			time_s1  <= edge_time;
		end
	end

	// edge logic
	metr_step #(
		.TIME_BITS(TIME_BITS)
	) u_step (
		.state_q(state_q),
		.mark_q (mark_q),
		.high_q (high_q),
		.full_q (full_q),
		.half_q (half_q),
		.level  (level_s1),
		.now    (TIME_BITS'(time_s1)),
		.state_n(state_n),
		.mark_n (mark_n),
		.high_n (high_n),
		.full_n (full_n),
		.half_n (half_n),
		.res    (res)
	);

	// receiver state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAITING;
			mark_q  <= '0;
			high_q  <= '0;
			full_q  <= '0;
			half_q  <= '0;
		end else if (adv) begin
			state_q <= state_n;
			mark_q  <= mark_n;
			high_q  <= high_n;
			full_q  <= full_n;
			half_q  <= half_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q      <= res;
			half_out_q <= 32'(half_n);
		end
	end

	assign out_valid           = out_valid_q;
	assign event_res           = res_q.event_res;
	assign bit_value           = res_q.bit_value;
	assign learned_half_period = half_out_q;

`ifndef SYNTHESIS
	// receiver state only moves when a word passes to the result register
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q) && $stable(half_q))
		else $error("receiver state changed without a word");

	// a sync event always lands in init
	a_sync_init: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.event_res == EV_SYNC |=> state_q == ST_INIT)
		else $error("sync reported without entering init");

	// the reported half period follows the learned full period on sync
	a_sync_half: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.event_res == EV_SYNC |-> half_q == (full_q >> 1))
		else $error("half period does not match full period at sync");

	// a set bit only comes with a data event
	a_bit_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.bit_value |-> res_q.event_res == EV_BIT)
		else $error("bit value set without a data event");
`endif

endmodule

[hdl/metr_step.sv]
// ----------------------------------------------------------------------------
// metr_step
// Next-state logic for one line edge: interval measurement, lock check,
// single/double/too-long classification and the receiver state machine.
// ----------------------------------------------------------------------------
module metr_step #(
	parameter int TIME_BITS = 32
) (
	input  metr_pkg::metr_state_t state_q,
	input  logic [TIME_BITS-1:0]  mark_q,
	input  logic [TIME_BITS-1:0]  high_q,
	input  logic [TIME_BITS-1:0]  full_q,
	input  logic [TIME_BITS-1:0]  half_q,
	input  logic                  level,
	input  logic [TIME_BITS-1:0]  now,
	output metr_pkg::metr_state_t state_n,
	output logic [TIME_BITS-1:0]  mark_n,
	output logic [TIME_BITS-1:0]  high_n,
	output logic [TIME_BITS-1:0]  full_n,
	output logic [TIME_BITS-1:0]  half_n,
	output metr_pkg::metr_res_t   res
);
	import metr_pkg::*;

	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS-1:0] margin;
	logic [TIME_BITS-1:0] diff;
	logic                 too_long;
	logic                 dbl;
	logic                 lock;

	// interval since last mark, wraps with the timestamp
	assign elapsed  = now - mark_q;
	assign margin   = elapsed - (elapsed >> TOL_SHIFT);
	assign too_long = margin > full_q;
	assign dbl      = !too_long && (margin > half_q);

	// low time must match high time within 1/64
	assign diff = (high_q > elapsed) ? (high_q - elapsed) : (elapsed - high_q);
	assign lock = ((high_q >> TOL_SHIFT) >= diff) && (high_q != '0);

	// receiver state machine
	always_comb begin
		state_n       = state_q;
		mark_n        = mark_q;
		high_n        = high_q;
		full_n        = full_q;
		half_n        = half_q;
		res.event_res = EV_NONE;
		res.bit_value = 1'b0;
		unique case (state_q)
			ST_INIT, ST_MID, ST_START: begin
				mark_n = now;
				if (too_long || (dbl && state_q == ST_START)) begin
					// lost lock: restart the sync search on this edge
					if (level) begin
						state_n = ST_SYNC_HIGH;
					end else begin
						high_n  = '0;
						state_n = ST_SYNC_LOW;
					end
				end else if (dbl) begin
					state_n       = ST_MID;
					res.event_res = EV_BIT;
					res.bit_value = level;
				end else begin
					unique case (state_q)
						ST_INIT: begin
							state_n = ST_ERROR;
						end
						ST_MID: begin
							state_n = ST_START;
						end
						default: begin
							state_n       = ST_MID;
							res.event_res = EV_BIT;
							res.bit_value = level;
						end
					endcase
				end
			end
			ST_SYNC_HIGH: begin
				if (!level) begin
					high_n  = elapsed;
					mark_n  = now;
					state_n = ST_SYNC_LOW;
				end
			end
			ST_SYNC_LOW: begin
				if (level) begin
					mark_n = now;
					if (lock) begin
						full_n        = high_q;
						half_n        = high_q >> 1;
						res.event_res = EV_SYNC;
						state_n       = ST_INIT;
					end else begin
						state_n = ST_WAITING;
					end
				end
			end
			ST_ERROR: begin
				if (!level) begin
					state_n = ST_WAITING;
				end
			end
			default: begin
				// waiting for a rising edge
				if (level) begin
					state_n = ST_SYNC_HIGH;
					mark_n  = now;
				end else begin
					state_n = ST_WAITING;
				end
			end
		endcase
	end

endmodule
